FILE: rtl/mwlfo_pkg.sv
// Package for the multi-wave software LFO: widths, codes, state encoding
// and the request bundle of the shared multiplier.
// No dependencies.
`default_nettype none

package mwlfo_pkg;

  localparam int VALUE_BITS = 16;   // width of the wrapping LFO value (16 to 32)
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    WAVE_TRI      = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_RAND     = 3'd3,
    WAVE_TRI_ONE  = 3'd4,
    WAVE_TRI_SQ   = 3'd5,
    WAVE_ONESHOT  = 3'd6,
    WAVE_RAND_ALT = 3'd7
  } wave_e;

  typedef enum logic [2:0] {
    REG_WAVEFORM      = 3'd0,
    REG_SPEED         = 3'd1,
    REG_INITIAL_STEP  = 3'd2,
    REG_HALF_PERIOD   = 3'd3,
    REG_START_DELAY   = 3'd4,
    REG_DEPTH_RATE    = 3'd5,
    REG_DEPTH_CHANGE  = 3'd6,
    REG_DEPTH_REPEATS = 3'd7
  } reg_idx_e;

  typedef enum logic {
    KIND_RESTART = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_MUL,
    S_MUL2,
    S_WAVE,
    S_DEPTH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

FILE: rtl/multi_wave_software_lfo.sv
// Multi-wave software LFO top level: config registers, sequencer, output register.
// Depends on mwlfo_pkg and mwlfo_mul.
//
// Usage: configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle. Requests arrive on the in_valid_i/in_ready_o channel;
// each request gives exactly one result on out_valid_o/out_ready_i.
// A restart request or a request that only consumes start delay goes from idle
// straight to the done state. An advance runs 'steps' LFO iterations in turn on
// a single sequencer: a step is the iteration state alone when the speed divider
// does not fire; else the wave state follows, straight for triangle, saw and
// one-shot, after one shared-multiplier pass for squared triangle and square,
// after two for random, plus the depth state for a depth-modulation update.
// in_ready_o is high only while the sequencer is idle; one request at a time.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; only a second result waits for the first to go.
// Reset sets all but the data registers to their reset values, speed and depth
// rate to 1; old_q, rw_q, amp_q, out_value_q and out_changed_q are not reset.
`default_nettype none

module multi_wave_software_lfo
  import mwlfo_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic        [2:0] cfg_idx_i,
  input  wire logic        [7:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              kind_i,
  input  wire logic        [7:0] steps_i,
  input  wire logic       [15:0] random_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed     [15:0] lfo_value_o,
  output logic                   changed_o
);

  // configuration
  wave_e             waveform_q;
  logic        [7:0] speed_q, half_period_q, start_delay_q, depth_rate_q, depth_repeats_q;
  logic signed [7:0] initial_step_q, depth_change_q;

  // LFO state
  logic        [7:0] delay_q, delay_d;
  logic        [7:0] spd_q, spd_d;
  logic signed [7:0] step_q, step_d;
  logic        [8:0] time_q, time_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic        [7:0] drc_q, drc_d;
  logic        [7:0] dleft_q, dleft_d;

  // sequencer
  state_e            state_q, state_d;
  logic        [7:0] n_q, n_d;
  logic [VALUE_BITS-1:0] old_q, old_d;
  logic       [15:0] rw_q, rw_d;
  logic       [15:0] amp_q, amp_d;
  logic              neg_pend_q, neg_pend_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic signed [15:0] out_value_q, out_value_d;
  logic              out_changed_q, out_changed_d;

  mul_req_t           mul_req;
  logic [MUL_P_W-1:0] prod;
  logic         [8:0] step_mag;

  function automatic logic signed [7:0] neg8(input logic signed [7:0] s);
    logic signed [7:0] r;
    r = (s == -8'sd128) ? 8'sd127 : -s;
    return r;
  endfunction

  mwlfo_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // magnitude of the step, 128 for the most negative code
  assign step_mag = step_q[7] ? (9'd0 - {step_q[7], step_q}) : {1'b0, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q      <= WAVE_TRI;
      speed_q         <= 8'd1;
      initial_step_q  <= '0;
      half_period_q   <= '0;
      start_delay_q   <= '0;
      depth_rate_q    <= 8'd1;
      depth_change_q  <= '0;
      depth_repeats_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WAVEFORM:      waveform_q      <= wave_e'(cfg_data_i[2:0]);
        REG_SPEED:         speed_q         <= cfg_data_i;
        REG_INITIAL_STEP:  initial_step_q  <= cfg_data_i;
        REG_HALF_PERIOD:   half_period_q   <= cfg_data_i;
        REG_START_DELAY:   start_delay_q   <= cfg_data_i;
        REG_DEPTH_RATE:    depth_rate_q    <= cfg_data_i;
        REG_DEPTH_CHANGE:  depth_change_q  <= cfg_data_i;
        REG_DEPTH_REPEATS: depth_repeats_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      delay_q     <= '0;
      spd_q       <= '0;
      step_q      <= '0;
      time_q      <= '0;
      value_q     <= '0;
      drc_q       <= '0;
      dleft_q     <= '0;
      n_q         <= '0;
      neg_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      delay_q     <= delay_d;
      spd_q       <= spd_d;
      step_q      <= step_d;
      time_q      <= time_d;
      value_q     <= value_d;
      drc_q       <= drc_d;
      dleft_q     <= dleft_d;
      n_q         <= n_d;
      neg_pend_q  <= neg_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q         <= old_d;
    rw_q          <= rw_d;
    amp_q         <= amp_d;
    out_value_q   <= out_value_d;
    out_changed_q <= out_changed_d;
  end

  always_comb begin
    logic [8:0]            t;
    logic                  rev;
    logic [VALUE_BITS-1:0] sum;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] term;
    logic [VALUE_BITS-1:0] step_x;
    logic signed [9:0]     a;
    logic signed [9:0]     s_x;
    logic signed [9:0]     dc_x;
    logic signed [7:0]     s;
    logic [7:0]            dr;

    state_d       = state_q;
    delay_d       = delay_q;
    spd_d         = spd_q;
    step_d        = step_q;
    time_d        = time_q;
    value_d       = value_q;
    drc_d         = drc_q;
    dleft_d       = dleft_q;
    n_d           = n_q;
    old_d         = old_q;
    rw_d          = rw_q;
    amp_d         = amp_q;
    neg_pend_d    = neg_pend_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_value_d   = out_value_q;
    out_changed_d = out_changed_q;
    mul_req.en    = 1'b0;
    mul_req.a     = MUL_A_W'(step_mag);
    mul_req.b     = (waveform_q == WAVE_TRI_SQ) ? MUL_B_W'(step_mag) : MUL_B_W'(time_q);

    step_x = {{(VALUE_BITS-8){step_q[7]}}, step_q};
    mag    = VALUE_BITS'(prod[16:0]);
    term   = step_q[7] ? (VALUE_BITS'(0) - mag) : mag;
    t      = time_q;
    rev    = 1'b0;
    sum    = value_q + step_x;
    a      = '0;
    s      = step_q;
    dr     = drc_q;
    s_x    = {{2{step_q[7]}}, step_q};
    dc_x   = {{2{depth_change_q[7]}}, depth_change_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          old_d = value_q;
          rw_d  = random_word_i;
          if (kind_e'(kind_i) == KIND_RESTART) begin
            value_d = '0;
            delay_d = start_delay_q;
            step_d  = initial_step_q;
            time_d  = {1'b0, half_period_q};
            dleft_d = depth_repeats_q;
            if (waveform_q == WAVE_SQUARE || waveform_q == WAVE_RAND) begin
              spd_d = 8'd1;
            end else begin
              spd_d = speed_q + 8'd1;
            end
            state_d = S_DONE;
          end else if (delay_q != 8'd0) begin
            delay_d = delay_q - 8'd1;
            state_d = S_DONE;
          end else begin
            n_d     = steps_i;
            state_d = S_ITER;
          end
        end
      end

      S_ITER: begin
        if (n_q == 8'd0) begin
          state_d = S_DONE;
        end else begin
          n_d = n_q - 8'd1;
          if (spd_q != 8'd1) begin
            if (spd_q != 8'd255) begin
              spd_d = spd_q - 8'd1;
            end
          end else begin
            spd_d = speed_q;
            case (waveform_q) inside
              WAVE_SQUARE, WAVE_RAND, WAVE_RAND_ALT, WAVE_TRI_SQ: state_d = S_MUL;
              default:                                            state_d = S_WAVE;
            endcase
          end
        end
      end

      S_MUL: begin
        mul_req.en = 1'b1;
        if (waveform_q == WAVE_RAND || waveform_q == WAVE_RAND_ALT) begin
          state_d = S_MUL2;
        end else begin
          state_d = S_WAVE;
        end
      end

      S_MUL2: begin
        // second pass: random word times (2*amp + 1)
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(rw_q);
        mul_req.b  = {prod[15:0], 1'b1};
        amp_d      = prod[15:0];
        state_d    = S_WAVE;
      end

      S_WAVE: begin
        state_d = S_ITER;
        case (waveform_q) inside
          WAVE_TRI, WAVE_TRI_ONE, WAVE_TRI_SQ: begin
            sum = value_q + ((waveform_q == WAVE_TRI_SQ) ? term : step_x);
            value_d = sum;
            if (t != 9'd255) begin
              t = t - 9'd1;
              if (t == 9'd0) begin
                t   = (waveform_q == WAVE_TRI_ONE) ? {1'b0, half_period_q}
                                                   : {half_period_q, 1'b0};
                rev = 1'b1;
              end
            end
            time_d = t;
            if (sum == '0) begin
              // depth update sees the step before the reversal
              neg_pend_d = rev;
              state_d    = S_DEPTH;
            end else if (rev) begin
              step_d = neg8(step_q);
            end
          end
          WAVE_SQUARE: begin
            value_d    = term;
            neg_pend_d = 1'b1;
            state_d    = S_DEPTH;
          end
          WAVE_ONESHOT: begin
            if (time_q != 9'd0) begin
              if (time_q != 9'd255) begin
                time_d = time_q - 9'd1;
              end
              value_d = sum;
            end
          end
          WAVE_SAW: begin
            value_d = sum;
            if (t != 9'd255) begin
              t = t - 9'd1;
              if (t == 9'd0) begin
                value_d    = VALUE_BITS'(0) - sum;
                neg_pend_d = 1'b0;
                state_d    = S_DEPTH;
                t          = {half_period_q, 1'b0};
              end
            end
            time_d = t;
          end
          default: begin
            // random: amp - r, r spans 0 .. 2*amp
            value_d    = VALUE_BITS'(amp_q) - VALUE_BITS'(prod[MUL_P_W-1:16]);
            neg_pend_d = 1'b0;
            state_d    = S_DEPTH;
          end
        endcase
      end

      S_DEPTH: begin
        dr = drc_q - 8'd1;
        if (dr == 8'd0) begin
          dr = depth_rate_q;
          if (dleft_q != 8'd0) begin
            if (dleft_q <= 8'd127) begin
              dleft_d = dleft_q - 8'd1;
            end
            if (step_q[7]) begin
              a = dc_x - s_x;
              if (a < 10'sd128) begin
                s = 8'(-a);
              end else begin
                s = depth_change_q[7] ? 8'sd0 : -8'sd127;
              end
            end else begin
              a = s_x + dc_x;
              if (a < 10'sd128) begin
                s = a[7:0];
              end else begin
                s = depth_change_q[7] ? 8'sd0 : 8'sd127;
              end
            end
          end
        end
        drc_d   = dr;
        step_d  = neg_pend_q ? neg8(s) : s;
        state_d = S_ITER;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_value_d   = value_q[15:0];
          out_changed_d = (value_q != old_q);
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign lfo_value_o = out_value_q;
  assign changed_o   = out_changed_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_mul2_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL2) |-> ($past(state_q) == S_MUL))
    else $error("second multiplier pass without first");

  a_mul_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (waveform_q == WAVE_SQUARE || waveform_q == WAVE_RAND ||
                            waveform_q == WAVE_RAND_ALT || waveform_q == WAVE_TRI_SQ))
    else $error("multiplier used for a waveform that needs none");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("result not loaded into free output register");

endmodule

`default_nettype wire

FILE: rtl/mwlfo_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on mwlfo_pkg for operand widths and the request bundle.
`default_nettype none

module mwlfo_mul
  import mwlfo_pkg::*;
(
  input  wire logic               clk_i,
  input  wire mul_req_t           req_i,
  output logic      [MUL_P_W-1:0] prod_o
);

  logic [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: test/multi_wave_software_lfo_tb.sv
// Self-checking testbench for multi_wave_software_lfo: directed and random requests with
// their own LFO predictor, random idling on both sides and one long receiver hold-off.
// Depends on mwlfo_pkg and the RTL of the block.
module multi_wave_software_lfo_tb;
  import mwlfo_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_MAX  = 10000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_REQS    = 60;

  typedef struct {
    kind_e       kind;
    logic [7:0]  steps;
    logic [15:0] rword;
  } lfo_req_t;

  typedef struct {
    logic [15:0] value;
    logic        changed;
  } lfo_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_WAVEFORM;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = KIND_RESTART;
  logic [7:0]  steps_i = '0;
  logic [15:0] random_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] lfo_value_o;
  logic        changed_o;

  multi_wave_software_lfo DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .steps_i      (steps_i),
    .random_word_i(random_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lfo_value_o  (lfo_value_o),
    .changed_o    (changed_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lfo_req_t pending_reqs[$];
  lfo_out_t expected_vals[$];
  lfo_req_t drv_req;
  lfo_out_t want;
  int       errors = 0;
  int       results_seen = 0;
  int       send_gap = 0;
  int       stall_left = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;
  bit       gaps_on = 1'b1;
  bit       hold_req = 1'b0;

  // predictor copy of the registers
  wave_e             cfg_wave = WAVE_TRI;
  logic [7:0]        cfg_speed = 8'd1;
  logic signed [7:0] cfg_istep = '0;
  logic [7:0]        cfg_half = '0;
  logic [7:0]        cfg_delay = '0;
  logic [7:0]        cfg_drate = 8'd1;
  logic signed [7:0] cfg_dchange = '0;
  logic [7:0]        cfg_dreps = '0;

  // predictor state
  logic [7:0]  m_delay = '0;
  logic [7:0]  m_speed_cnt = '0;
  int          m_step = 0;
  logic [8:0]  m_time = '0;
  logic [15:0] m_value = '0;
  logic [7:0]  m_drate_cnt = '0;
  logic [7:0]  m_depth_left = '0;

  function automatic int magnitude(int s);
    return (s < 0) ? -s : s;
  endfunction

  // negation of -128 saturates
  function automatic int flip(int s);
    return (s == -128) ? 127 : -s;
  endfunction

  function automatic void model_write(reg_idx_e idx, logic [7:0] v);
    case (idx)
      REG_WAVEFORM:      cfg_wave = wave_e'(v[2:0]);
      REG_SPEED:         cfg_speed = v;
      REG_INITIAL_STEP:  cfg_istep = v;
      REG_HALF_PERIOD:   cfg_half = v;
      REG_START_DELAY:   cfg_delay = v;
      REG_DEPTH_RATE:    cfg_drate = v;
      REG_DEPTH_CHANGE:  cfg_dchange = v;
      REG_DEPTH_REPEATS: cfg_dreps = v;
      default: ;
    endcase
  endfunction

  function automatic void depth_tick();
    int a;
    int dc;
    dc = cfg_dchange;
    m_drate_cnt = m_drate_cnt - 8'd1;
    if (m_drate_cnt != 0) return;
    m_drate_cnt = cfg_drate;
    if (m_depth_left == 0) return;
    if (m_depth_left <= 8'd127) m_depth_left = m_depth_left - 8'd1;
    if (m_step < 0) begin
      a = dc - m_step;
      if (a < 128) m_step = -a;
      else m_step = (dc < 0) ? 0 : -127;
    end else begin
      a = m_step + dc;
      if (a < 128) m_step = a;
      else m_step = (dc < 0) ? 0 : 127;
    end
  endfunction

  function automatic void lfo_tick(logic [15:0] rw);
    int         ax;
    int         tc;
    logic [8:0] t;
    longint     amp;
    longint     r;
    if (m_speed_cnt != 8'd1) begin
      if (m_speed_cnt != 8'd255) m_speed_cnt = m_speed_cnt - 8'd1;
      return;
    end
    m_speed_cnt = cfg_speed;
    tc = m_time;
    case (cfg_wave)
      WAVE_TRI, WAVE_TRI_ONE, WAVE_TRI_SQ: begin
        ax = (cfg_wave == WAVE_TRI_SQ) ? magnitude(m_step) * m_step : m_step;
        m_value = m_value + 16'(ax);
        if (m_value == 0) depth_tick();
        t = m_time;
        if (t != 9'd255) begin
          t = t - 9'd1;
          if (t == 0) begin
            t = {1'b0, cfg_half};
            if (cfg_wave != WAVE_TRI_ONE) t = t + t;
            m_time = t;
            m_step = flip(m_step);
            return;
          end
        end
        m_time = t;
      end
      WAVE_SQUARE: begin
        m_value = 16'(m_step * tc);
        depth_tick();
        m_step = flip(m_step);
      end
      WAVE_ONESHOT: begin
        if (m_time != 0) begin
          if (m_time != 9'd255) m_time = m_time - 9'd1;
          m_value = m_value + 16'(m_step);
        end
      end
      WAVE_SAW: begin
        m_value = m_value + 16'(m_step);
        t = m_time;
        if (t != 9'd255) begin
          t = t - 9'd1;
          if (t == 0) begin
            m_value = -m_value;
            depth_tick();
            t = {cfg_half, 1'b0};
          end
        end
        m_time = t;
      end
      default: begin
        // random: scaled so that the offset spans 0 to twice the amplitude
        amp = longint'(magnitude(m_step)) * longint'(tc);
        r = (longint'(rw) * (2 * amp + 1)) >> 16;
        m_value = 16'(amp - r);
        depth_tick();
      end
    endcase
  endfunction

  function automatic lfo_out_t lfo_predict(kind_e k, logic [7:0] n, logic [15:0] rw);
    lfo_out_t    o;
    logic [15:0] prev;
    prev = m_value;
    if (k == KIND_RESTART) begin
      m_value = '0;
      m_delay = cfg_delay;
      m_step = cfg_istep;
      m_time = {1'b0, cfg_half};
      m_depth_left = cfg_dreps;
      if (cfg_wave == WAVE_SQUARE || cfg_wave == WAVE_RAND) m_speed_cnt = 8'd1;
      else m_speed_cnt = cfg_speed + 8'd1;
    end else if (m_delay != 0) begin
      m_delay = m_delay - 8'd1;
    end else begin
      for (int i = 0; i < n; i++) lfo_tick(rw);
    end
    o.value = m_value;
    o.changed = (m_value != prev);
    return o;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte(int small_max);
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return $urandom_range(0, 1) ? 8'h7F : 8'h80;
      3, 4: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, small_max));
    endcase
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_vals.push_back(lfo_predict(kind_e'(kind_i), steps_i, random_word_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drv_req = pending_reqs.pop_front();
          kind_i <= drv_req.kind;
          steps_i <= drv_req.steps;
          random_word_i <= drv_req.rword;
          in_valid_i <= 1'b1;
          send_gap = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_vals.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = expected_vals.pop_front();
          if (lfo_value_o !== want.value || changed_o !== want.changed)
            flag_error($sformatf("result %0d: value %h changed %b, expected value %h changed %b",
                                 results_seen, lfo_value_o, changed_o, want.value,
                                 want.changed));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = gaps_on ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_vals.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    model_write(idx, v);
  endtask

  task automatic set_cfg(wave_e w, logic [7:0] sp, logic [7:0] is, logic [7:0] hp,
                         logic [7:0] sd, logic [7:0] dr, logic [7:0] dc, logic [7:0] dn);
    wait_idle();
    write_reg(REG_WAVEFORM, {5'b0, w});
    write_reg(REG_SPEED, sp);
    write_reg(REG_INITIAL_STEP, is);
    write_reg(REG_HALF_PERIOD, hp);
    write_reg(REG_START_DELAY, sd);
    write_reg(REG_DEPTH_RATE, dr);
    write_reg(REG_DEPTH_CHANGE, dc);
    write_reg(REG_DEPTH_REPEATS, dn);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_req(kind_e k, logic [7:0] n, logic [15:0] rw);
    lfo_req_t q;
    q.kind = k;
    q.steps = n;
    q.rword = rw;
    pending_reqs.push_back(q);
  endtask

  task automatic add_random_req();
    lfo_req_t q;
    int       r;
    q.kind = ($urandom_range(0, 99) < 5) ? KIND_RESTART : KIND_ADVANCE;
    r = $urandom_range(0, 99);
    if (r < 50) q.steps = 8'd1;
    else if (r < 85) q.steps = 8'($urandom_range(0, 8));
    else if (r < 97) q.steps = 8'($urandom_range(9, 40));
    else q.steps = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(41, 255));
    case ($urandom_range(0, 9))
      0: q.rword = 16'h0000;
      1: q.rword = 16'hFFFF;
      default: q.rword = 16'($urandom_range(0, 65535));
    endcase
    pending_reqs.push_back(q);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // divider wrap, time wrap from zero, start delay, zero steps, -128 step
    set_cfg(WAVE_TRI, 8'd0, 8'h80, 8'd0, 8'd2, 8'd0, 8'h7F, 8'hFF);
    add_req(KIND_RESTART, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd1, 16'h0000);
    add_req(KIND_ADVANCE, 8'd1, 16'hFFFF);
    add_req(KIND_ADVANCE, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd3, 16'h5A5A);
    add_req(KIND_ADVANCE, 8'hFF, 16'hA5A5);

    // squared triangle, held time count, value overflow
    set_cfg(WAVE_TRI_SQ, 8'd1, 8'h7F, 8'hFF, 8'd0, 8'd1, 8'h80, 8'd128);
    add_req(KIND_RESTART, 8'hFF, 16'hFFFF);
    add_req(KIND_ADVANCE, 8'hFF, 16'h0000);
    add_req(KIND_ADVANCE, 8'd2, 16'h1234);

    // square with negation saturating
    set_cfg(WAVE_SQUARE, 8'd1, 8'h80, 8'hFF, 8'd0, 8'd2, 8'd5, 8'd3);
    add_req(KIND_RESTART, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd4, 16'h0000);
    add_req(KIND_ADVANCE, 8'd1, 16'h0000);

    // random at the word extremes
    set_cfg(WAVE_RAND_ALT, 8'd1, 8'h80, 8'hFF, 8'd0, 8'd1, 8'd0, 8'd0);
    add_req(KIND_RESTART, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd1, 16'hFFFF);
    add_req(KIND_ADVANCE, 8'd1, 16'h0000);
    add_req(KIND_ADVANCE, 8'd2, 16'h8000);

    // saw reversing on its first step and on every second step after it
    set_cfg(WAVE_SAW, 8'd2, 8'd100, 8'd1, 8'd0, 8'hFF, 8'hC0, 8'd127);
    add_req(KIND_RESTART, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd8, 16'h0000);

    // one shot behind the longest start delay
    set_cfg(WAVE_ONESHOT, 8'd1, 8'hFF, 8'd3, 8'hFF, 8'd1, 8'd1, 8'd1);
    add_req(KIND_RESTART, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd1, 16'h0000);
    add_req(KIND_RESTART, 8'd5, 16'h0000);

    set_cfg(WAVE_RAND, 8'd1, 8'd50, 8'd2, 8'd0, 8'd1, 8'd3, 8'd4);
    add_req(KIND_RESTART, 8'd0, 16'h0000);
    add_req(KIND_ADVANCE, 8'd3, 16'h1234);

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_cfg(wave_e'($urandom_range(0, 7)), pick_byte(3), pick_byte(255), pick_byte(8),
              ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 40))
                                          : 8'($urandom_range(0, 2)),
              pick_byte(3), pick_byte(255), pick_byte(6));
      gaps_on = (p == 2) || ($urandom_range(0, 3) != 0);
      if (p == 2) hold_req = 1'b1;
      add_req(KIND_RESTART, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      for (int j = 1; j < PHASE_REQS; j++) add_random_req();
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    errors += expected_vals.size();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mwlfo_pkg.sv
rtl/mwlfo_mul.sv
rtl/multi_wave_software_lfo.sv
test/multi_wave_software_lfo_tb.sv
